// File: src/sfcsa_pkg.sv
`default_nettype none

package sfcsa_pkg;

  localparam logic [7:0]  CrcPoly       = 8'h31;
  localparam logic [15:0] StatusMask    = 16'hFFFC;
  localparam logic        ModeTemp      = 1'b0;
  localparam logic        ModeHum       = 1'b1;
  localparam logic [3:0]  FramesReset   = 4'd10;

  localparam logic [14:0] TempCoeff     = 15'd17572;
  localparam logic [14:0] HumCoeff      = 15'd1250;
  localparam logic [30:0] TempOffset    = 31'd307036160;
  localparam logic [30:0] HumOffset     = 31'd3932160;
  localparam logic [15:0] TempBias      = 16'd4690;
  localparam logic [15:0] TempBiasTenth = 16'd469;
  localparam logic [15:0] RecipTen      = 16'd52429;
  localparam int          RecipShift    = 19;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] check_byte;
  } in_t;

  typedef struct packed {
    logic               crc_ok;
    logic               reading_done;
    logic signed [11:0] average_tenths;
    logic [3:0]         valid_frames;
  } out_t;

  typedef struct packed {
    logic        mode;
    logic        crc_ok;
    logic [15:0] word;
  } item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/sfcsa_front.sv
`default_nettype none

module sfcsa_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  sfcsa_pkg::in_t       in_i,
  output logic                 full_o,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output sfcsa_pkg::item_t     q_item_o
);

  typedef enum logic [1:0] {FIdle, FHigh, FLow} state_e;

  state_e          state_q;
  sfcsa_pkg::in_t  frame_q;
  logic [7:0]      crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      case (state_q)
        FIdle: begin
          if (push_i) begin
            frame_q <= in_i;
            state_q <= FHigh;
          end
        end
        FHigh: begin
          crc_q   <= sfcsa_pkg::crc8_byte(8'h00, frame_q.data_high);
          state_q <= FLow;
        end
        FLow: begin
          if (!q_full_i) begin
            state_q <= FIdle;
          end
        end
        default: begin
          state_q <= FIdle;
        end
      endcase
    end
  end

  assign full_o          = (state_q != FIdle);
  assign q_push_o        = (state_q == FLow) && !q_full_i;
  assign q_item_o.mode   = frame_q.mode;
  assign q_item_o.word   = {frame_q.data_high, frame_q.data_low} & sfcsa_pkg::StatusMask;
  assign q_item_o.crc_ok = (sfcsa_pkg::crc8_byte(crc_q, frame_q.data_low) == frame_q.check_byte);

endmodule

`default_nettype wire

// File: src/sfcsa_queue.sv
`default_nettype none

module sfcsa_queue #(
  parameter int Depth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  sfcsa_pkg::item_t     item_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output sfcsa_pkg::item_t     item_o,
  output logic                 empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfcsa_pkg::item_t  slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        slots_q[wr_ptr_q] <= item_i;
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sfcsa_back.sv
`default_nettype none

module sfcsa_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [3:0]            frames_i,
  input  wire                  q_empty_i,
  input  sfcsa_pkg::item_t     q_item_i,
  output logic                 q_pop_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output sfcsa_pkg::out_t      result_o
);

  typedef enum logic [2:0] {BIdle, BMul, BRec, BAcc, BUpd, BDiv, BFin, BOut} state_e;

  state_e            state_q;
  sfcsa_pkg::item_t  item_q;
  sfcsa_pkg::out_t   res_q;
  sfcsa_pkg::out_t   out_q;
  logic              out_valid_q;
  logic [15:0]       sum_q;
  logic [3:0]        vcount_q;
  logic [3:0]        index_q;
  logic [30:0]       prod_q;
  logic [15:0]       quot_q;
  logic [15:0]       u_q;
  logic              frac_q;
  logic [30:0]       recip_q;
  logic [15:0]       dvd_q;
  logic [3:0]        rem_q;
  logic [3:0]        div_q;
  logic [3:0]        cnt_q;
  logic              neg_q;

  logic              is_temp;
  logic [14:0]       coeff;
  logic [30:0]       offset;
  logic [31:0]       num;
  logic [15:0]       q1;
  logic [15:0]       u;
  logic [11:0]       qq;
  logic [15:0]       times10;
  logic [15:0]       tq;
  logic [15:0]       step;
  logic              inexact;
  logic [15:0]       acc;
  logic [15:0]       acc_adj;
  logic [4:0]        limit;
  logic              done;
  logic [4:0]        shifted;
  logic              ge;
  logic [4:0]        rem_next;
  logic [15:0]       avg;

  assign is_temp = (item_q.mode == sfcsa_pkg::ModeTemp);
  assign coeff   = is_temp ? sfcsa_pkg::TempCoeff : sfcsa_pkg::HumCoeff;
  assign offset  = is_temp ? sfcsa_pkg::TempOffset : sfcsa_pkg::HumOffset;
  assign num     = {1'b0, prod_q} - {1'b0, offset};
  assign q1      = num[31:16];
  assign u       = q1 + sfcsa_pkg::TempBias;

  assign qq      = 12'(recip_q >> sfcsa_pkg::RecipShift);
  assign times10 = 16'({qq, 3'b000}) + 16'({qq, 1'b0});
  assign tq      = 16'(qq) - sfcsa_pkg::TempBiasTenth;
  assign step    = is_temp ? tq : quot_q;
  assign inexact = frac_q || (is_temp && (u_q != times10));
  assign acc     = sum_q + step;
  assign acc_adj = acc + {15'b0, inexact && acc[15]};

  assign limit   = (frames_i == 4'd0) ? 5'd1 : {1'b0, frames_i};
  assign done    = ({1'b0, index_q} + 5'd1) >= limit;

  assign shifted  = {rem_q, dvd_q[15]};
  assign ge       = shifted >= {1'b0, div_q};
  assign rem_next = ge ? shifted - {1'b0, div_q} : shifted;
  assign avg      = neg_q ? -dvd_q : dvd_q;

  assign q_pop_o  = (state_q == BIdle) && !q_empty_i;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      vcount_q    <= '0;
      index_q     <= '0;
    end else begin
      if (pop_i && out_valid_q && (state_q != BOut)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BIdle: begin
          if (!q_empty_i) begin
            item_q  <= q_item_i;
            state_q <= q_item_i.crc_ok ? BMul : BUpd;
          end
        end
        BMul: begin
          prod_q  <= coeff * item_q.word;
          state_q <= BRec;
        end
        BRec: begin
          quot_q  <= q1;
          frac_q  <= (num[15:0] != 16'd0);
          u_q     <= u;
          recip_q <= u[14:0] * sfcsa_pkg::RecipTen;
          state_q <= BAcc;
        end
        BAcc: begin
          sum_q    <= acc_adj;
          vcount_q <= vcount_q + 4'd1;
          state_q  <= BUpd;
        end
        BUpd: begin
          res_q.crc_ok         <= item_q.crc_ok;
          res_q.reading_done   <= done;
          res_q.valid_frames   <= vcount_q;
          res_q.average_tenths <= '0;
          if (done) begin
            sum_q    <= '0;
            vcount_q <= '0;
            index_q  <= '0;
            if (vcount_q != 4'd0) begin
              dvd_q   <= sum_q[15] ? -sum_q : sum_q;
              neg_q   <= sum_q[15];
              div_q   <= vcount_q;
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= BDiv;
            end else begin
              state_q <= BOut;
            end
          end else begin
            index_q <= index_q + 4'd1;
            state_q <= BOut;
          end
        end
        BDiv: begin
          rem_q <= rem_next[3:0];
          dvd_q <= {dvd_q[14:0], ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= BFin;
          end
        end
        BFin: begin
          res_q.average_tenths <= avg[11:0];
          state_q <= BOut;
        end
        BOut: begin
          if (!out_valid_q || pop_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= BIdle;
          end
        end
        default: begin
          state_q <= BIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/sensor_frame_crc_scale_average.sv
`default_nettype none

// Checks each three-byte sensor frame with CRC-8 (polynomial 0x31), scales valid words to
// tenths of a degree or of a percent humidity, and gives one result per frame, with the
// truncated average on the last frame of each reading. The front end takes one frame at a
// time through two CRC byte steps. The back end runs a failed frame through update and
// output states, a valid one also through multiply, reciprocal and accumulate states, and
// the last frame of a reading with valid frames also through the 16-step bit-serial divider.
// A queue of QueueDepth requests between the two lets frames arrive while the back end works.
module sensor_frame_crc_scale_average #(
  parameter int QueueDepth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  output logic                 full_o,
  input  sfcsa_pkg::in_t       data_i,
  input  wire                  pop_i,
  output logic                 empty_o,
  output sfcsa_pkg::out_t      result_o,
  input  wire                  cfg_we_i,
  input  wire [3:0]            cfg_wdata_i
);

  logic [3:0]        frames_q;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  sfcsa_pkg::item_t  q_in;
  sfcsa_pkg::item_t  q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= sfcsa_pkg::FramesReset;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  sfcsa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .in_i     (data_i),
    .full_o   (full_o),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  sfcsa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  sfcsa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frames_i  (frames_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

// File: src/sfcsa_checker.sv
`default_nettype none

module sfcsa_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             push_i,
  input wire             full_o,
  input wire             pop_i,
  input wire             empty_o,
  input sfcsa_pkg::out_t result_o
);

  // A waiting result stays in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(result_o)))
    else $error("waiting result changed");

  // The front end is busy for the cycles after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> full_o)
    else $error("front end accepted back to back");

  // Only the last frame of a reading carries an average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !result_o.reading_done) |-> (result_o.average_tenths == 12'sd0))
    else $error("average outside the last frame");

  // A reading without valid frames averages to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.reading_done && (result_o.valid_frames == 4'd0))
      |-> (result_o.average_tenths == 12'sd0))
    else $error("nonzero average with no valid frame");

endmodule

bind sensor_frame_crc_scale_average sfcsa_checker u_sfcsa_checker (.*);

`default_nettype wire
